[hdl/backbone_to_spring_moduli_macros.svh]
// ----------------------------------------------------------------------------
// backbone_to_spring_moduli assertion macros
// shorthand for the concurrent checks of the spring moduli block
// ----------------------------------------------------------------------------
`ifndef BACKBONE_TO_SPRING_MODULI_MACROS_SVH
`define BACKBONE_TO_SPRING_MODULI_MACROS_SVH

// antecedent implies consequent in the same cycle
`define B2SM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define B2SM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/b2sm_pkg.sv]
// ----------------------------------------------------------------------------
// b2sm_pkg
// constants, status codes and helpers of the spring moduli block
// ----------------------------------------------------------------------------
package b2sm_pkg;

   localparam int DATA_WIDTH_DEF  = 48;
   localparam int STRAIN_INT_BITS = 8;
   localparam int POISSON_W       = 16;
   localparam int FACTOR_W        = POISSON_W + 2;
   localparam int MOD_FRAC        = 16;
   localparam int SQRT3_W         = 31;
   localparam int YIELD_SHIFT     = 14;
   localparam int STATUS_W        = 2;

   localparam logic [POISSON_W-1:0] POISSON_RESET = 16'd19661;
   localparam logic [SQRT3_W-1:0]   SQRT3_Q30     = 31'h6ED9EBA1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_MOD  = 2'd1,
      STATUS_ZERO_STEP = 2'd2,
      STATUS_SAT       = 2'd3
   } status_type;

   function automatic status_type join_flags(input status_type a, input status_type b);
      status_type res;
      if (a == STATUS_ZERO_STEP || b == STATUS_ZERO_STEP) begin
         res = STATUS_ZERO_STEP;
      end else if (a == STATUS_SAT || b == STATUS_SAT) begin
         res = STATUS_SAT;
      end else begin
         res = STATUS_OK;
      end
      return res;
   endfunction

endpackage

[hdl/backbone_to_spring_moduli.sv]
// ----------------------------------------------------------------------------
// backbone_to_spring_moduli
// iwan spring moduli and yield strains from a piecewise-linear backbone curve
//
// req: one backbone point per word, tdata = strain (lowest), stress; tlast
// marks the final point of a layer. rsp: one spring per word, tdata =
// youngs modulus (lowest), yield strain; tuser = status; tlast marks the
// final spring. csr: write enable and poisson ratio (q0.16), taken at any
// edge with csr_wr_en high, reset value 19661.
// A spring leaves one point after its own point; the first point of a
// multi-point curve gives none, a final point after an earlier point gives
// two, and every other point gives one. The restoring slope divider, the
// bit-serial multipliers and the yield divider each work one bit per cycle,
// and req_tready stays low until the block is through with the point.
// Results sit in an output register; a stalled rsp holds the word and the
// block waits before loading the next spring. Reset (synchronous) empties
// the output, clears the stored previous point and reloads the poisson ratio.
// ----------------------------------------------------------------------------
`include "backbone_to_spring_moduli_macros.svh"

module backbone_to_spring_moduli #(
   parameter int DATA_WIDTH = b2sm_pkg::DATA_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [b2sm_pkg::POISSON_W-1:0]         csr_wr_data,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // strain_point, stress_point
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      req_tdata,
   input  logic                                   req_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // youngs_modulus, yield_strain
   output logic [((2*DATA_WIDTH+7)/8)*8-1:0]      rsp_tdata,
   // status
   output logic [b2sm_pkg::STATUS_W-1:0]          rsp_tuser,
   output logic                                   rsp_tlast
);

   import b2sm_pkg::*;

   localparam int W           = DATA_WIDTH;
   localparam int STRAIN_FRAC = W - STRAIN_INT_BITS;
   localparam int TDATA_W     = ((2*W+7)/8)*8;
   localparam int CNT_W       = $clog2(W);
   localparam logic [W-1:0] HALF_C   = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MAXPOS_C = {1'b0, {(W-1){1'b1}}};

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_DIFF = 8'b0000_0010,
      ST_PREP = 8'b0000_0100,
      ST_DIV  = 8'b0000_1000,
      ST_PACK = 8'b0001_0000,
      ST_GSET = 8'b0010_0000,
      ST_RES  = 8'b0100_0000,
      ST_EMIT = 8'b1000_0000
   } state_type;

   // sign and magnitude of a - b for two signed words
   function automatic logic [W:0] sdiff_f(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W-1:0] ua;
      logic [W-1:0] ub;
      ua = a ^ HALF_C;
      ub = b ^ HALF_C;
      return (ua >= ub) ? {1'b0, ua - ub} : {1'b1, ub - ua};
   endfunction

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [POISSON_W-1:0] nu_ff, nu_in;
   logic [W-1:0] prior_strain_ff, prior_strain_in;
   logic [W-1:0] prior_stress_ff, prior_stress_in;
   logic [W-1:0] prior_slope_ff, prior_slope_in;
   status_type prior_flag_ff, prior_flag_in;
   logic have_prior_ff, have_prior_in;
   logic second_ff, second_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [W-1:0] cur_strain_ff, cur_strain_in;
   logic [W-1:0] cur_stress_ff, cur_stress_in;
   logic cur_last_ff, cur_last_in;
   logic [W-1:0] cur_slope_ff, cur_slope_in;
   status_type cur_flag_ff, cur_flag_in;
   logic neg_ff, neg_in;
   logic zero_step_ff, zero_step_in;
   logic pre_over_ff, pre_over_in;
   logic [W-1:0] dm_ff, dm_in;
   logic [W-1:0] sdv_rem_ff, sdv_rem_in;
   logic [W-1:0] sdv_q_ff, sdv_q_in;
   logic [W-1:0] smul_x_ff, smul_x_in;
   logic [SQRT3_W-1:0] smul_acc_ff, smul_acc_in;
   logic [W-1:0] smul_lo_ff, smul_lo_in;
   logic [FACTOR_W-1:0] ydv_rem_ff, ydv_rem_in;
   logic [W-1:0] ydv_q_ff, ydv_q_in;
   logic [W-1:0] gmul_x_ff, gmul_x_in;
   logic [FACTOR_W-1:0] gmul_acc_ff, gmul_acc_in;
   logic [W-1:0] gmul_lo_ff, gmul_lo_in;
   logic gneg_ff, gneg_in;
   status_type res_flag_ff, res_flag_in;
   logic res_last_ff, res_last_in;
   logic [W-1:0] rsp_youngs_ff, rsp_youngs_in;
   logic [W-1:0] rsp_yield_ff, rsp_yield_in;
   status_type rsp_status_ff, rsp_status_in;
   logic rsp_last_ff, rsp_last_in;

   logic [W-1:0] req_strain;
   logic [W-1:0] req_stress;
   logic [FACTOR_W-1:0] factor;
   logic strain_ge;
   logic [W-1:0] dm_c;
   logic [W:0] stress_sd;
   logic [W-1:0] sm_hi;
   logic [W:0] sdv_t;
   logic sdv_ge;
   logic [SQRT3_W:0] smul_sum;
   logic [FACTOR_W:0] ydv_t;
   logic ydv_ge;
   logic [FACTOR_W:0] gmul_sum;
   logic q_over;
   logic use_prior;
   logic [W:0] g_sd;
   logic [W-1:0] slope_abs;
   logic [W+FACTOR_W-1:0] prod;
   logic [W+1:0] e_mag;
   logic e_sat;
   logic [W-1:0] youngs_c;
   status_type status_c;
   logic commit;

   assign req_strain = req_tdata[W-1:0];
   assign req_stress = req_tdata[2*W-1:W];
   assign factor     = {1'b1, nu_ff, 1'b0};

   // point differences
   assign strain_ge = cur_strain_ff >= prior_strain_ff;
   assign dm_c      = strain_ge ? cur_strain_ff - prior_strain_ff
                                : prior_strain_ff - cur_strain_ff;
   assign stress_sd = sdiff_f(cur_stress_ff, prior_stress_ff);
   assign sm_hi     = sdv_q_ff >> STRAIN_INT_BITS;

   // slope divider step
   assign sdv_t  = {sdv_rem_ff, sdv_q_ff[W-1]};
   assign sdv_ge = sdv_t >= {1'b0, dm_ff};
   assign q_over = pre_over_ff | (neg_ff ? (sdv_q_ff[W-1] & (|sdv_q_ff[W-2:0]))
                                         : sdv_q_ff[W-1]);

   // strain times sqrt3, lsb first
   assign smul_sum = {1'b0, smul_acc_ff} + (smul_x_ff[0] ? {1'b0, SQRT3_Q30} : '0);

   // yield divider step
   assign ydv_t  = {ydv_rem_ff, ydv_q_ff[W-1]};
   assign ydv_ge = ydv_t >= {1'b0, factor};

   // modulus times 2(1+nu), lsb first
   assign gmul_sum = {1'b0, gmul_acc_ff} + (gmul_x_ff[0] ? {1'b0, factor} : '0);

   assign use_prior = have_prior_ff & ~second_ff;
   assign g_sd      = sdiff_f(prior_slope_ff, cur_slope_ff);
   assign slope_abs = cur_slope_ff[W-1] ? -cur_slope_ff : cur_slope_ff;

   assign prod  = {gmul_acc_ff, gmul_lo_ff};
   assign e_mag = (W+2)'(prod >> MOD_FRAC);
   assign e_sat = gneg_ff ? ((|e_mag[W+1:W]) | (e_mag[W-1] & (|e_mag[W-2:0])))
                          : (|e_mag[W+1:W-1]);
   assign youngs_c = e_sat ? (gneg_ff ? HALF_C : MAXPOS_C)
                           : (gneg_ff ? -e_mag[W-1:0] : e_mag[W-1:0]);

   always_comb begin
      if (res_flag_ff == STATUS_ZERO_STEP) begin
         status_c = STATUS_ZERO_STEP;
      end else if (res_flag_ff == STATUS_SAT || e_sat) begin
         status_c = STATUS_SAT;
      end else if (e_mag == '0) begin
         status_c = STATUS_ZERO_MOD;
      end else begin
         status_c = STATUS_OK;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      nu_in           = csr_wr_en ? csr_wr_data : nu_ff;
      prior_strain_in = prior_strain_ff;
      prior_stress_in = prior_stress_ff;
      prior_slope_in  = prior_slope_ff;
      prior_flag_in   = prior_flag_ff;
      have_prior_in   = have_prior_ff;
      second_in       = second_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_tready;
      cur_strain_in   = cur_strain_ff;
      cur_stress_in   = cur_stress_ff;
      cur_last_in     = cur_last_ff;
      cur_slope_in    = cur_slope_ff;
      cur_flag_in     = cur_flag_ff;
      neg_in          = neg_ff;
      zero_step_in    = zero_step_ff;
      pre_over_in     = pre_over_ff;
      dm_in           = dm_ff;
      sdv_rem_in      = sdv_rem_ff;
      sdv_q_in        = sdv_q_ff;
      smul_x_in       = smul_x_ff;
      smul_acc_in     = smul_acc_ff;
      smul_lo_in      = smul_lo_ff;
      ydv_rem_in      = ydv_rem_ff;
      ydv_q_in        = ydv_q_ff;
      gmul_x_in       = gmul_x_ff;
      gmul_acc_in     = gmul_acc_ff;
      gmul_lo_in      = gmul_lo_ff;
      gneg_in         = gneg_ff;
      res_flag_in     = res_flag_ff;
      res_last_in     = res_last_ff;
      rsp_youngs_in   = rsp_youngs_ff;
      rsp_yield_in    = rsp_yield_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_last_in     = rsp_last_ff;
      commit          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cur_strain_in = req_strain;
               cur_stress_in = req_stress;
               cur_last_in   = req_tlast;
               second_in     = 1'b0;
               state_in      = ST_DIFF;
            end
         end
         ST_DIFF: begin
            dm_in    = dm_c;
            sdv_q_in = stress_sd[W-1:0];
            neg_in   = ~strain_ge ^ stress_sd[W];
            state_in = ST_PREP;
         end
         ST_PREP: begin
            zero_step_in = dm_ff == '0;
            pre_over_in  = sm_hi >= dm_ff;
            sdv_rem_in   = sm_hi;
            sdv_q_in     = sdv_q_ff << STRAIN_FRAC;
            smul_x_in    = have_prior_ff ? prior_strain_ff : cur_strain_ff;
            smul_acc_in  = '0;
            cnt_in       = CNT_W'(W-1);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            sdv_rem_in  = sdv_ge ? W'(sdv_t - {1'b0, dm_ff}) : sdv_t[W-1:0];
            sdv_q_in    = {sdv_q_ff[W-2:0], sdv_ge};
            smul_lo_in  = {smul_sum[0], smul_lo_ff[W-1:1]};
            smul_acc_in = smul_sum[SQRT3_W:1];
            smul_x_in   = smul_x_ff >> 1;
            cnt_in      = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_PACK;
            end
         end
         ST_PACK: begin
            if (zero_step_ff) begin
               cur_slope_in = '0;
               cur_flag_in  = STATUS_ZERO_STEP;
            end else if (q_over) begin
               cur_slope_in = neg_ff ? HALF_C : MAXPOS_C;
               cur_flag_in  = STATUS_SAT;
            end else begin
               cur_slope_in = neg_ff ? -sdv_q_ff : sdv_q_ff;
               cur_flag_in  = STATUS_OK;
            end
            if (have_prior_ff || cur_last_ff) begin
               state_in = ST_GSET;
            end else begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_GSET: begin
            gmul_x_in   = use_prior ? g_sd[W-1:0] : slope_abs;
            gneg_in     = use_prior ? g_sd[W] : cur_slope_ff[W-1];
            res_flag_in = use_prior ? join_flags(prior_flag_ff, cur_flag_ff) : cur_flag_ff;
            res_last_in = ~use_prior;
            gmul_acc_in = '0;
            ydv_rem_in  = FACTOR_W'(smul_acc_ff >> YIELD_SHIFT);
            ydv_q_in    = W'({smul_acc_ff[YIELD_SHIFT-1:0], smul_lo_ff} >> YIELD_SHIFT);
            smul_x_in   = cur_strain_ff;
            smul_acc_in = '0;
            cnt_in      = CNT_W'(W-1);
            state_in    = ST_RES;
         end
         ST_RES: begin
            gmul_lo_in  = {gmul_sum[0], gmul_lo_ff[W-1:1]};
            gmul_acc_in = gmul_sum[FACTOR_W:1];
            gmul_x_in   = gmul_x_ff >> 1;
            ydv_rem_in  = ydv_ge ? FACTOR_W'(ydv_t - {1'b0, factor}) : ydv_t[FACTOR_W-1:0];
            ydv_q_in    = {ydv_q_ff[W-2:0], ydv_ge};
            smul_lo_in  = {smul_sum[0], smul_lo_ff[W-1:1]};
            smul_acc_in = smul_sum[SQRT3_W:1];
            smul_x_in   = smul_x_ff >> 1;
            cnt_in      = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_youngs_in = youngs_c;
               rsp_yield_in  = ydv_q_ff;
               rsp_status_in = status_c;
               rsp_last_in   = res_last_ff;
               if (!res_last_ff && cur_last_ff) begin
                  second_in = 1'b1;
                  state_in  = ST_GSET;
               end else begin
                  commit   = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (commit) begin
         second_in = 1'b0;
         if (cur_last_ff) begin
            prior_strain_in = '0;
            prior_stress_in = '0;
            prior_slope_in  = '0;
            prior_flag_in   = STATUS_OK;
            have_prior_in   = 1'b0;
         end else begin
            prior_strain_in = cur_strain_ff;
            prior_stress_in = cur_stress_ff;
            prior_slope_in  = cur_slope_in;
            prior_flag_in   = cur_flag_in;
            have_prior_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         nu_ff           <= POISSON_RESET;
         prior_strain_ff <= '0;
         prior_stress_ff <= '0;
         prior_slope_ff  <= '0;
         prior_flag_ff   <= STATUS_OK;
         have_prior_ff   <= 1'b0;
         second_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         nu_ff           <= nu_in;
         prior_strain_ff <= prior_strain_in;
         prior_stress_ff <= prior_stress_in;
         prior_slope_ff  <= prior_slope_in;
         prior_flag_ff   <= prior_flag_in;
         have_prior_ff   <= have_prior_in;
         second_ff       <= second_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_strain_ff <= cur_strain_in;
      cur_stress_ff <= cur_stress_in;
      cur_last_ff   <= cur_last_in;
      cur_slope_ff  <= cur_slope_in;
      cur_flag_ff   <= cur_flag_in;
      neg_ff        <= neg_in;
      zero_step_ff  <= zero_step_in;
      pre_over_ff   <= pre_over_in;
      dm_ff         <= dm_in;
      sdv_rem_ff    <= sdv_rem_in;
      sdv_q_ff      <= sdv_q_in;
      smul_x_ff     <= smul_x_in;
      smul_acc_ff   <= smul_acc_in;
      smul_lo_ff    <= smul_lo_in;
      ydv_rem_ff    <= ydv_rem_in;
      ydv_q_ff      <= ydv_q_in;
      gmul_x_ff     <= gmul_x_in;
      gmul_acc_ff   <= gmul_acc_in;
      gmul_lo_ff    <= gmul_lo_in;
      gneg_ff       <= gneg_in;
      res_flag_ff   <= res_flag_in;
      res_last_ff   <= res_last_in;
      rsp_youngs_ff <= rsp_youngs_in;
      rsp_yield_ff  <= rsp_yield_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'({rsp_yield_ff, rsp_youngs_ff});
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   `B2SM_ASSERT_NEXT(a_accept_starts_diff, clock, reset, req_tvalid && req_tready, state_ff == ST_DIFF, "accepted point did not start the difference step")
   `B2SM_ASSERT_SAME(a_load_from_emit, clock, reset, $rose(rsp_tvalid), $past(state_ff == ST_EMIT), "result loaded outside the emit step")
   `B2SM_ASSERT_SAME(a_zero_mod_value, clock, reset, rsp_tvalid && rsp_tuser == STATUS_ZERO_MOD, rsp_tdata[W-1:0] == '0, "zero modulus status on a nonzero modulus")
   `B2SM_ASSERT_SAME(a_second_busy, clock, reset, second_ff, !req_tready, "second spring pending while taking points")

endmodule

[tb/backbone_to_spring_moduli_tb.sv]
// ----------------------------------------------------------------------------
// backbone_to_spring_moduli_tb
// self-checking bench for the spring moduli block
//
// Feeds backbone points, first a handful of hand-picked curves (origin and
// full-scale points, flat and equal segments, zero and backward strain steps,
// slope and modulus clipping), then random well-formed curves mixed with raw
// noise, under several poisson ratios including the extremes. A scoreboard
// class predicts every spring word and checks the rsp stream in order. Both
// sides idle at random, the receiver once holds off long enough to back the
// block up, and the ratio is also changed while a curve is left open.
// ----------------------------------------------------------------------------
module backbone_to_spring_moduli_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import b2sm_pkg::*;

   localparam int W     = DATA_WIDTH_DEF;
   localparam int FRAC  = W - STRAIN_INT_BITS;
   localparam int BUS_W = ((2*W+7)/8)*8;

   typedef logic [W-1:0] word_type;
   localparam word_type HALF = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      word_type   modulus;
      word_type   yield_val;
      status_type status;
      logic       last;
   } spring_type;

   class moduli_board_type;
      logic [POISSON_W-1:0] poisson;
      word_type             prev_strain;
      word_type             prev_stress;
      word_type             prev_slope;
      status_type           prev_flag;
      bit                   open_curve;
      spring_type           springs_due[$];
      int                   faults;

      function new();
         poisson     = POISSON_RESET;
         prev_strain = '0;
         prev_stress = '0;
         prev_slope  = '0;
         prev_flag   = STATUS_OK;
         open_curve  = 1'b0;
         faults      = 0;
      endfunction

      // signed a - b as sign and magnitude
      function word_type gap(input word_type a, input word_type b, output bit neg);
         word_type ua;
         word_type ub;
         ua  = a ^ HALF;
         ub  = b ^ HALF;
         neg = (ua < ub);
         return neg ? ub - ua : ua - ub;
      endfunction

      function word_type clip(input bit neg, input logic [63:0] mag, inout bit clipped);
         logic [63:0] top;
         top = 64'(HALF);
         if (neg) begin
            if (mag > top) begin
               mag     = top;
               clipped = 1'b1;
            end
            return word_type'(64'd0 - mag);
         end
         if (mag > top - 64'd1) begin
            mag     = top - 64'd1;
            clipped = 1'b1;
         end
         return word_type'(mag);
      endfunction

      // floor(num * 2^FRAC / den), all ones past 2^(W-1)
      function logic [63:0] quotient(input word_type num, input word_type den);
         logic [127:0] n;
         logic [127:0] d;
         logic [127:0] q;
         n = 128'(num) << FRAC;
         d = 128'(den);
         q = n / d;
         if (q > 128'(HALF)) return '1;
         return q[63:0];
      endfunction

      function status_type merge(input status_type a, input status_type b);
         if (a == STATUS_ZERO_STEP || b == STATUS_ZERO_STEP) return STATUS_ZERO_STEP;
         if (a == STATUS_SAT || b == STATUS_SAT) return STATUS_SAT;
         return STATUS_OK;
      endfunction

      function spring_type spring_of(input bit neg, input logic [63:0] mag,
                                     input status_type flag, input word_type strain,
                                     input bit last);
         logic [63:0]  f;
         logic [63:0]  e;
         logic [127:0] p;
         logic [127:0] d;
         bit           clipped;
         spring_type   s;
         f         = 2 * (64'd65536 + 64'(poisson));
         e         = (mag >> 16) * f + (((mag & 64'hFFFF) * f) >> 16);
         clipped   = 1'b0;
         s.modulus = clip(neg, e, clipped);
         if (flag == STATUS_ZERO_STEP) begin
            s.status = STATUS_ZERO_STEP;
         end else if (flag == STATUS_SAT || clipped) begin
            s.status = STATUS_SAT;
         end else if (s.modulus == '0) begin
            s.status = STATUS_ZERO_MOD;
         end else begin
            s.status = STATUS_OK;
         end
         p           = 128'(strain) * 128'(SQRT3_Q30);
         d           = 128'(f) << YIELD_SHIFT;
         s.yield_val = word_type'(p / d);
         s.last      = last;
         return s;
      endfunction

      function void take_point(input word_type strain, input word_type stress, input bit last);
         word_type   step_mag;
         word_type   stress_mag;
         word_type   slope;
         word_type   g_mag;
         bit         step_neg;
         bit         stress_neg;
         bit         g_neg;
         bit         clipped;
         status_type flag;
         clipped = 1'b0;
         flag    = STATUS_OK;
         if (strain >= prev_strain) begin
            step_mag = strain - prev_strain;
            step_neg = 1'b0;
         end else begin
            step_mag = prev_strain - strain;
            step_neg = 1'b1;
         end
         stress_mag = gap(stress, prev_stress, stress_neg);
         if (step_mag == '0) begin
            slope = '0;
            flag  = STATUS_ZERO_STEP;
         end else begin
            slope = clip(step_neg ^ stress_neg, quotient(stress_mag, step_mag), clipped);
            if (clipped) flag = STATUS_SAT;
         end
         if (open_curve) begin
            g_mag = gap(prev_slope, slope, g_neg);
            springs_due.push_back(spring_of(g_neg, 64'(g_mag), merge(prev_flag, flag),
                                            prev_strain, 1'b0));
         end
         if (last) begin
            g_neg = slope[W-1];
            g_mag = g_neg ? word_type'(-slope) : slope;
            springs_due.push_back(spring_of(g_neg, 64'(g_mag), flag, strain, 1'b1));
            prev_strain = '0;
            prev_stress = '0;
            prev_slope  = '0;
            prev_flag   = STATUS_OK;
            open_curve  = 1'b0;
         end else begin
            prev_strain = strain;
            prev_stress = stress;
            prev_slope  = slope;
            prev_flag   = flag;
            open_curve  = 1'b1;
         end
      endfunction

      function void report(input string what, input logic [63:0] want, input logic [63:0] got);
         faults++;
         $display("%0t %s mismatch: expected %h actual %h", $time, what, want, got);
      endfunction

      function void check_spring(input word_type modulus, input word_type yield_val,
                                 input logic [STATUS_W-1:0] status, input logic last);
         spring_type due;
         if (springs_due.size() == 0) begin
            report("unexpected word", 64'(modulus), 64'(yield_val));
            return;
         end
         due = springs_due.pop_front();
         if (modulus !== due.modulus) report("modulus", 64'(due.modulus), 64'(modulus));
         if (yield_val !== due.yield_val) report("yield", 64'(due.yield_val), 64'(yield_val));
         if (status !== due.status) report("status", 64'(due.status), 64'(status));
         if (last !== due.last) report("last", 64'(due.last), 64'(last));
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [POISSON_W-1:0] csr_wr_data;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [BUS_W-1:0]     req_tdata;
   logic                 req_tlast;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [BUS_W-1:0]     rsp_tdata;
   logic [STATUS_W-1:0]  rsp_tuser;
   logic                 rsp_tlast;

   moduli_board_type ledger = new();
   bit               steady = 1'b0;
   bit               hold_off_req = 1'b0;
   int               sent = 0;

   backbone_to_spring_moduli #(
      .DATA_WIDTH (W)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic word_type rand_field(input int width);
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      if (width <= 0) return '0;
      return word_type'(raw >> (64 - width));
   endfunction

   task automatic offer_point(input word_type strain, input word_type stress, input bit last);
      while (!steady && $urandom_range(99, 0) < 17) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= BUS_W'({stress, strain});
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      ledger.take_point(strain, stress, last);
      sent++;
   endtask

   task automatic drain();
      do @(posedge clock); while (ledger.springs_due.size() != 0);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      drain();
      repeat (200) @(posedge clock);
   endtask

   task automatic set_poisson(input logic [POISSON_W-1:0] ratio);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ratio;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ledger.poisson = ratio;
   endtask

   task automatic random_curve();
      int       len;
      word_type strain;
      word_type stress;
      word_type step;
      word_type delta;
      len    = $urandom_range(8, 1);
      strain = '0;
      stress = '0;
      for (int k = 0; k < len; k++) begin
         step   = ($urandom_range(99, 0) < 4) ? '0 : rand_field($urandom_range(44, 1));
         strain = strain + step;
         delta  = rand_field($urandom_range(44, 0));
         if ($urandom_range(3, 0) == 0) delta = -delta;
         if ($urandom_range(99, 0) < 3) delta = rand_field(W);
         stress = stress + delta;
         offer_point(strain, stress, k == len - 1);
      end
   endtask

   task automatic run_phase(input int target, input int hold_at, input int pause_at);
      int start;
      start = sent;
      while (sent - start < target) begin
         if (hold_at >= 0 && sent - start >= hold_at) begin
            hold_off_req = 1'b1;
            hold_at      = -1;
         end
         if (pause_at >= 0 && sent - start >= pause_at) begin
            req_tvalid <= 1'b0;
            drain();
            pause_at = -1;
         end
         if ($urandom_range(99, 0) < 20) begin
            offer_point(rand_field($urandom_range(W, 1)), rand_field($urandom_range(W, 1)),
                        $urandom_range(2, 0) == 0);
         end else begin
            random_curve();
         end
      end
   endtask

   // receiver: checks words and paces rsp_tready
   initial begin
      int quiet;
      quiet      = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            ledger.check_spring(rsp_tdata[W-1:0], rsp_tdata[2*W-1:W], rsp_tuser, rsp_tlast);
         end
         if (hold_off_req && quiet == 0) begin
            quiet        = 3000;
            hold_off_req = 1'b0;
         end
         if (quiet > 0) begin
            quiet--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99, 0) >= 17);
         end
      end
   end

   initial begin
      logic [POISSON_W-1:0] ratios [6];
      int                   guard;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      ratios[0]   = 16'd0;
      ratios[1]   = 16'd32768;
      ratios[2]   = 16'hFFFF;
      ratios[3]   = 16'($urandom_range(32768, 0));
      ratios[4]   = 16'($urandom());
      ratios[5]   = 16'd1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // full-scale single point, then a point on the origin
      offer_point({W{1'b1}}, {1'b0, {(W-1){1'b1}}}, 1'b1);
      offer_point('0, '0, 1'b1);
      // softening curve
      offer_point(word_type'(1) << FRAC, word_type'(100) << 16, 1'b0);
      offer_point(word_type'(2) << FRAC, word_type'(150) << 16, 1'b0);
      offer_point(word_type'(3) << FRAC, word_type'(175) << 16, 1'b1);
      // equal slopes give zero moduli
      offer_point(word_type'(1) << FRAC, word_type'(10) << 16, 1'b0);
      offer_point(word_type'(2) << FRAC, word_type'(20) << 16, 1'b0);
      offer_point(word_type'(3) << FRAC, word_type'(30) << 16, 1'b1);
      // flat segment
      offer_point(word_type'(1) << FRAC, '0, 1'b1);
      // slope clipping both ways
      offer_point(word_type'(1), {1'b0, {(W-1){1'b1}}}, 1'b1);
      offer_point(word_type'(1), HALF, 1'b1);
      // strain going backwards
      offer_point(word_type'(2) << FRAC, word_type'(50) << 16, 1'b0);
      offer_point(word_type'(1) << FRAC, word_type'(60) << 16, 1'b1);
      // repeated strain mid-curve
      offer_point(word_type'(5) << FRAC, word_type'(3) << 16, 1'b0);
      offer_point(word_type'(5) << FRAC, word_type'(4) << 16, 1'b0);
      offer_point(word_type'(6) << FRAC, word_type'(5) << 16, 1'b1);
      // all ones then back to the origin
      offer_point({W{1'b1}}, {W{1'b1}}, 1'b0);
      offer_point('0, '0, 1'b1);
      // modulus clipping with in-range slopes
      offer_point(word_type'(1) << FRAC, word_type'(1) << 46, 1'b0);
      offer_point(word_type'(2) << FRAC, '0, 1'b0);
      offer_point(word_type'(3) << FRAC, '0, 1'b1);
      // left open across the ratio change
      offer_point(word_type'(1) << FRAC, word_type'(7) << 16, 1'b0);

      for (int ph = 0; ph < 6; ph++) begin
         settle();
         set_poisson(ratios[ph]);
         steady = (ph == 1);
         run_phase(260, (ph == 2) ? 40 : -1, (ph == 3) ? 120 : -1);
      end
      steady = 1'b0;

      req_tvalid <= 1'b0;
      for (guard = 0; guard < 100000 && ledger.springs_due.size() != 0; guard++) begin
         @(posedge clock);
      end
      repeat (200) @(posedge clock);
      if (ledger.springs_due.size() != 0) begin
         ledger.faults++;
         $display("%0t %0d words never arrived", $time, ledger.springs_due.size());
      end
      if (ledger.faults == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #15_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
